FILE: hw/rtl/anes_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// A* node expansion scorer. No dependencies.
`timescale 1ns / 1ps

package anes_pkg;

  localparam int MaxPos    = 8;
  localparam int MaxConfs  = 16;
  localparam int PosW      = 3;
  localparam int ConfW     = 4;
  localparam int CntW      = 5;
  localparam int NposW     = 4;
  localparam int EnergyW   = 32;
  localparam int SumW      = 40;
  localparam int SingleAw  = PosW + ConfW;
  localparam int PairAw    = 2 * (PosW + ConfW);
  localparam int MinAw     = PosW + ConfW + PosW;

  // input kinds
  localparam logic [2:0] KIND_SINGLE = 3'd0;
  localparam logic [2:0] KIND_PAIR   = 3'd1;
  localparam logic [2:0] KIND_COUNT  = 3'd2;
  localparam logic [2:0] KIND_BUILD  = 3'd3;
  localparam logic [2:0] KIND_NODE   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_NUM_POS = 2'd0;
  localparam logic [1:0] REG_CONST   = 2'd1;

  // datapath accumulator operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_G_INIT = 4'd1;
  localparam logic [3:0] OP_G_ADD  = 4'd2;
  localparam logic [3:0] OP_E_LOAD = 4'd3;
  localparam logic [3:0] OP_E_ADD  = 4'd4;
  localparam logic [3:0] OP_BEST   = 4'd5;
  localparam logic [3:0] OP_H_INIT = 4'd6;
  localparam logic [3:0] OP_H_ADD  = 4'd7;
  localparam logic [3:0] OP_M_LOAD = 4'd8;
  localparam logic [3:0] OP_M_MIN  = 4'd9;

  // read data source
  localparam logic [1:0] SRC_SINGLE = 2'd0;
  localparam logic [1:0] SRC_PAIR   = 2'd1;
  localparam logic [1:0] SRC_MIN    = 2'd2;

  typedef struct packed {
    logic                in_take;
    logic [3:0]          op;
    logic [1:0]          src;
    logic                first;
    logic [SingleAw-1:0] single_addr;
    logic [PairAw-1:0]   pair_addr;
    logic [MinAw-1:0]    min_addr;
    logic                min_we;
    logic                out_load;
    logic [PosW-1:0]     out_pos;
    logic [ConfW-1:0]    out_conf;
    logic                out_leaf;
    logic                out_last;
    logic                node_clear;
  } anes_cmd_t;

  typedef struct packed {
    logic [MaxPos-1:0]            flags;
    logic [MaxPos-1:0][ConfW-1:0] choice;
    logic [MaxPos-1:0][CntW-1:0]  cnt;
    logic [NposW-1:0]             npos;
    logic                         out_free;
  } anes_sts_t;

endpackage

FILE: hw/rtl/anes_dpath.sv
// Datapath: energy memories, node state, configuration, saturating
// accumulators and result register. Depends on anes_pkg.
`timescale 1ns / 1ps

module anes_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [anes_pkg::EnergyW-1:0] cfg_wdata_i,
  input  logic [2:0]                   kind_i,
  input  logic [anes_pkg::PosW-1:0]    pos_a_i,
  input  logic [anes_pkg::ConfW-1:0]   conf_a_i,
  input  logic [anes_pkg::PosW-1:0]    pos_b_i,
  input  logic [anes_pkg::ConfW-1:0]   conf_b_i,
  input  logic signed [anes_pkg::EnergyW-1:0] energy_value_i,
  input  logic [anes_pkg::CntW-1:0]    conf_count_i,
  input  logic                         is_assigned_i,
  input  anes_pkg::anes_cmd_t          cmd_i,
  output anes_pkg::anes_sts_t          sts_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [anes_pkg::PosW-1:0]    child_position_o,
  output logic [anes_pkg::ConfW-1:0]   child_conf_o,
  output logic signed [anes_pkg::SumW-1:0] exact_score_o,
  output logic signed [anes_pkg::SumW-1:0] bound_score_o,
  output logic                         parent_was_leaf_o,
  output logic                         last_child_o
);
  import anes_pkg::*;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] a,
                                                     input logic signed [SumW-1:0] b);
    logic signed [SumW:0] s;
    s = {a[SumW-1], a} + {b[SumW-1], b};
    if (s[SumW] != s[SumW-1]) begin
      sat_add = s[SumW] ? SumMin : SumMax;
    end else begin
      sat_add = s[SumW-1:0];
    end
  endfunction

  logic [EnergyW-1:0] single_mem [2**SingleAw];
  logic [EnergyW-1:0] pair_mem [2**PairAw];
  logic [EnergyW-1:0] min_mem [2**MinAw];
  logic [EnergyW-1:0] single_rd_q, pair_rd_q, min_rd_q;

  logic [MaxPos-1:0]            flags_q;
  logic [MaxPos-1:0][ConfW-1:0] choice_q;
  logic [MaxPos-1:0][CntW-1:0]  cnt_q;
  logic [NposW-1:0]             npos_q;
  logic signed [EnergyW-1:0]    const_q;

  logic signed [SumW-1:0] g_q, e_q, h_q, best_q;
  logic signed [EnergyW-1:0] m_q;
  logic signed [EnergyW-1:0] rdata;
  logic signed [SumW-1:0] rdata_ext;

  logic                    out_valid_q;
  logic [PosW-1:0]         pos_q;
  logic [ConfW-1:0]        conf_q;
  logic signed [SumW-1:0]  exact_q, bound_q;
  logic                    leaf_q, last_q;

  logic [CntW-1:0] cnt_clamped;
  logic [NposW-1:0] npos_clamped;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take && kind_i == KIND_SINGLE) begin
      single_mem[{pos_a_i, conf_a_i}] <= energy_value_i;
    end
    single_rd_q <= single_mem[cmd_i.single_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take && kind_i == KIND_PAIR && pos_a_i > pos_b_i) begin
      pair_mem[{pos_a_i, conf_a_i, pos_b_i, conf_b_i}] <= energy_value_i;
    end
    pair_rd_q <= pair_mem[cmd_i.pair_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.min_we) begin
      min_mem[cmd_i.min_addr] <= m_q;
    end
    min_rd_q <= min_mem[cmd_i.min_addr];
  end

  always_comb begin
    case (cmd_i.src)
      SRC_SINGLE: rdata = single_rd_q;
      SRC_PAIR:   rdata = pair_rd_q;
      SRC_MIN:    rdata = min_rd_q;
      default:    rdata = single_rd_q;
    endcase
    rdata_ext = {{(SumW-EnergyW){rdata[EnergyW-1]}}, rdata};
  end

  always_comb begin
    if (conf_count_i == '0) begin
      cnt_clamped = CntW'(1);
    end else if (conf_count_i > CntW'(MaxConfs)) begin
      cnt_clamped = CntW'(MaxConfs);
    end else begin
      cnt_clamped = conf_count_i;
    end
    if (cfg_wdata_i[NposW-1:0] == '0) begin
      npos_clamped = NposW'(1);
    end else if (cfg_wdata_i[NposW-1:0] > NposW'(MaxPos)) begin
      npos_clamped = NposW'(MaxPos);
    end else begin
      npos_clamped = cfg_wdata_i[NposW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      choice_q <= '0;
      for (int i = 0; i < MaxPos; i++) begin
        cnt_q[i] <= CntW'(1);
      end
      npos_q   <= NposW'(MaxPos);
      const_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_NUM_POS) begin
        npos_q <= npos_clamped;
      end
      if (cfg_we_i && cfg_idx_i == REG_CONST) begin
        const_q <= cfg_wdata_i;
      end
      if (cmd_i.in_take && kind_i == KIND_COUNT) begin
        cnt_q[pos_a_i] <= cnt_clamped;
      end
      if (cmd_i.node_clear) begin
        flags_q  <= '0;
        choice_q <= '0;
      end else if (cmd_i.in_take && kind_i == KIND_NODE) begin
        flags_q[pos_a_i]  <= is_assigned_i;
        choice_q[pos_a_i] <= is_assigned_i ? conf_a_i : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_G_INIT: g_q <= {{(SumW-EnergyW){const_q[EnergyW-1]}}, const_q};
      OP_G_ADD:  g_q <= sat_add(g_q, rdata_ext);
      OP_E_LOAD: e_q <= rdata_ext;
      OP_E_ADD:  e_q <= sat_add(e_q, rdata_ext);
      OP_BEST: begin
        if (cmd_i.first || e_q < best_q) begin
          best_q <= e_q;
        end
      end
      OP_H_INIT: h_q <= '0;
      OP_H_ADD:  h_q <= sat_add(h_q, best_q);
      OP_M_LOAD: m_q <= rdata;
      OP_M_MIN: begin
        if (rdata < m_q) begin
          m_q <= rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pos_q   <= cmd_i.out_pos;
      conf_q  <= cmd_i.out_conf;
      exact_q <= g_q;
      bound_q <= cmd_i.out_leaf ? '0 : h_q;
      leaf_q  <= cmd_i.out_leaf;
      last_q  <= cmd_i.out_last;
    end
  end

  assign sts_o.flags    = flags_q;
  assign sts_o.choice   = choice_q;
  assign sts_o.cnt      = cnt_q;
  assign sts_o.npos     = npos_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign child_position_o  = pos_q;
  assign child_conf_o      = conf_q;
  assign exact_score_o     = exact_q;
  assign bound_score_o     = bound_q;
  assign parent_was_leaf_o = leaf_q;
  assign last_child_o      = last_q;

endmodule

FILE: hw/rtl/anes_ctrl.sv
// Controller: sequences minima build and child scoring loops, each memory
// read taking a read state and an accumulate state. Depends on anes_pkg.
`timescale 1ns / 1ps

module anes_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  logic                last_element_i,
  input  anes_pkg::anes_sts_t sts_i,
  output anes_pkg::anes_cmd_t cmd_o
);
  import anes_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_BLD_P  = 5'd1;
  localparam logic [4:0] S_BLD_C  = 5'd2;
  localparam logic [4:0] S_BLD_Q  = 5'd3;
  localparam logic [4:0] S_BLD_RD = 5'd4;
  localparam logic [4:0] S_BLD_AC = 5'd5;
  localparam logic [4:0] S_BLD_WR = 5'd6;
  localparam logic [4:0] S_EXP    = 5'd7;
  localparam logic [4:0] S_G_INIT = 5'd8;
  localparam logic [4:0] S_G1_RD  = 5'd9;
  localparam logic [4:0] S_G1_AC  = 5'd10;
  localparam logic [4:0] S_G2_RD  = 5'd11;
  localparam logic [4:0] S_G2_AC  = 5'd12;
  localparam logic [4:0] S_H_P    = 5'd13;
  localparam logic [4:0] S_E_RD   = 5'd14;
  localparam logic [4:0] S_E_AC   = 5'd15;
  localparam logic [4:0] S_EA_RD  = 5'd16;
  localparam logic [4:0] S_EA_AC  = 5'd17;
  localparam logic [4:0] S_EM_RD  = 5'd18;
  localparam logic [4:0] S_EM_AC  = 5'd19;
  localparam logic [4:0] S_BEST   = 5'd20;
  localparam logic [4:0] S_H_ADD  = 5'd21;
  localparam logic [4:0] S_EMIT   = 5'd22;

  logic [4:0]       st_q, st_d;
  logic [NposW-1:0] p_q, p_d, q_q, q_d;
  logic [CntW-1:0]  c_q, c_d, k_q, k_d;
  logic [ConfW-1:0] cc_q, cc_d;
  logic [PosW-1:0]  np_q, np_d;
  logic             leaf_q, leaf_d;

  logic [MaxPos-1:0]            asg;
  logic [MaxPos-1:0][ConfW-1:0] cf;
  logic [PosW-1:0]              p3, q3;
  logic [PosW-1:0]              nxt;
  logic                         found;
  logic                         accept;
  logic                         child_last;

  assign p3 = p_q[PosW-1:0];
  assign q3 = q_q[PosW-1:0];
  assign accept = in_valid_i && (st_q == S_IDLE);
  assign in_stall_o = (st_q != S_IDLE);
  assign child_last = ({1'b0, cc_q} + CntW'(1)) == sts_i.cnt[np_q];

  // assignment of the child being scored
  always_comb begin
    for (int i = 0; i < MaxPos; i++) begin
      asg[i] = sts_i.flags[i] || (!leaf_q && np_q == PosW'(i));
      cf[i]  = (!leaf_q && np_q == PosW'(i)) ? cc_q : sts_i.choice[i];
    end
  end

  always_comb begin
    found = 1'b0;
    nxt   = '0;
    for (int i = 0; i < MaxPos; i++) begin
      if (!found && NposW'(i) < sts_i.npos && !sts_i.flags[i]) begin
        found = 1'b1;
        nxt   = PosW'(i);
      end
    end
  end

  always_comb begin
    st_d   = st_q;
    p_d    = p_q;
    q_d    = q_q;
    c_d    = c_q;
    k_d    = k_q;
    cc_d   = cc_q;
    np_d   = np_q;
    leaf_d = leaf_q;
    cmd_o  = '0;
    cmd_o.in_take = accept;

    case (st_q)
      S_IDLE: begin
        if (accept && kind_i == KIND_BUILD) begin
          p_d  = '0;
          st_d = S_BLD_P;
        end else if (accept && kind_i == KIND_NODE && last_element_i) begin
          st_d = S_EXP;
        end
      end
      S_BLD_P: begin
        if (p_q >= sts_i.npos) begin
          st_d = S_IDLE;
        end else begin
          c_d  = '0;
          st_d = S_BLD_C;
        end
      end
      S_BLD_C: begin
        if (c_q >= sts_i.cnt[p3]) begin
          p_d  = p_q + NposW'(1);
          st_d = S_BLD_P;
        end else begin
          q_d  = '0;
          st_d = S_BLD_Q;
        end
      end
      S_BLD_Q: begin
        if (q_q >= p_q) begin
          c_d  = c_q + CntW'(1);
          st_d = S_BLD_C;
        end else begin
          k_d  = '0;
          st_d = S_BLD_RD;
        end
      end
      S_BLD_RD: begin
        cmd_o.pair_addr = {p3, c_q[ConfW-1:0], q3, k_q[ConfW-1:0]};
        st_d = S_BLD_AC;
      end
      S_BLD_AC: begin
        cmd_o.src = SRC_PAIR;
        cmd_o.op  = (k_q == '0) ? OP_M_LOAD : OP_M_MIN;
        k_d = k_q + CntW'(1);
        st_d = (k_q + CntW'(1) < sts_i.cnt[q3]) ? S_BLD_RD : S_BLD_WR;
      end
      S_BLD_WR: begin
        cmd_o.min_addr = {p3, c_q[ConfW-1:0], q3};
        cmd_o.min_we   = 1'b1;
        q_d  = q_q + NposW'(1);
        st_d = S_BLD_Q;
      end
      S_EXP: begin
        np_d   = nxt;
        leaf_d = !found;
        cc_d   = '0;
        st_d   = S_G_INIT;
      end
      S_G_INIT: begin
        cmd_o.op = OP_G_INIT;
        p_d  = '0;
        st_d = S_G1_RD;
      end
      S_G1_RD: begin
        if (p_q >= sts_i.npos) begin
          p_d  = NposW'(1);
          q_d  = '0;
          st_d = S_G2_RD;
        end else if (asg[p3]) begin
          cmd_o.single_addr = {p3, cf[p3]};
          st_d = S_G1_AC;
        end else begin
          p_d = p_q + NposW'(1);
        end
      end
      S_G1_AC: begin
        cmd_o.src = SRC_SINGLE;
        cmd_o.op  = OP_G_ADD;
        p_d  = p_q + NposW'(1);
        st_d = S_G1_RD;
      end
      S_G2_RD: begin
        if (p_q >= sts_i.npos) begin
          if (leaf_q) begin
            st_d = S_EMIT;
          end else begin
            cmd_o.op = OP_H_INIT;
            p_d  = '0;
            st_d = S_H_P;
          end
        end else if (q_q >= p_q) begin
          p_d = p_q + NposW'(1);
          q_d = '0;
        end else if (asg[p3] && asg[q3]) begin
          cmd_o.pair_addr = {p3, cf[p3], q3, cf[q3]};
          st_d = S_G2_AC;
        end else begin
          q_d = q_q + NposW'(1);
        end
      end
      S_G2_AC: begin
        cmd_o.src = SRC_PAIR;
        cmd_o.op  = OP_G_ADD;
        q_d  = q_q + NposW'(1);
        st_d = S_G2_RD;
      end
      S_H_P: begin
        if (p_q >= sts_i.npos) begin
          st_d = S_EMIT;
        end else if (asg[p3]) begin
          p_d = p_q + NposW'(1);
        end else begin
          c_d  = '0;
          st_d = S_E_RD;
        end
      end
      S_E_RD: begin
        cmd_o.single_addr = {p3, c_q[ConfW-1:0]};
        st_d = S_E_AC;
      end
      S_E_AC: begin
        cmd_o.src = SRC_SINGLE;
        cmd_o.op  = OP_E_LOAD;
        q_d  = '0;
        st_d = S_EA_RD;
      end
      S_EA_RD: begin
        if (q_q >= sts_i.npos) begin
          q_d  = '0;
          st_d = S_EM_RD;
        end else if (asg[q3] && q_q != p_q) begin
          // higher position always addresses first
          if (p_q > q_q) begin
            cmd_o.pair_addr = {p3, c_q[ConfW-1:0], q3, cf[q3]};
          end else begin
            cmd_o.pair_addr = {q3, cf[q3], p3, c_q[ConfW-1:0]};
          end
          st_d = S_EA_AC;
        end else begin
          q_d = q_q + NposW'(1);
        end
      end
      S_EA_AC: begin
        cmd_o.src = SRC_PAIR;
        cmd_o.op  = OP_E_ADD;
        q_d  = q_q + NposW'(1);
        st_d = S_EA_RD;
      end
      S_EM_RD: begin
        if (q_q >= p_q) begin
          st_d = S_BEST;
        end else if (!asg[q3]) begin
          cmd_o.min_addr = {p3, c_q[ConfW-1:0], q3};
          st_d = S_EM_AC;
        end else begin
          q_d = q_q + NposW'(1);
        end
      end
      S_EM_AC: begin
        cmd_o.src = SRC_MIN;
        cmd_o.op  = OP_E_ADD;
        q_d  = q_q + NposW'(1);
        st_d = S_EM_RD;
      end
      S_BEST: begin
        cmd_o.op    = OP_BEST;
        cmd_o.first = (c_q == '0);
        c_d  = c_q + CntW'(1);
        st_d = (c_q + CntW'(1) < sts_i.cnt[p3]) ? S_E_RD : S_H_ADD;
      end
      S_H_ADD: begin
        cmd_o.op = OP_H_ADD;
        p_d  = p_q + NposW'(1);
        st_d = S_H_P;
      end
      S_EMIT: begin
        // hold until the result register frees up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_pos  = leaf_q ? '0 : np_q;
          cmd_o.out_conf = leaf_q ? '0 : cc_q;
          cmd_o.out_leaf = leaf_q;
          cmd_o.out_last = leaf_q || child_last;
          if (leaf_q || child_last) begin
            cmd_o.node_clear = 1'b1;
            st_d = S_IDLE;
          end else begin
            cc_d = cc_q + ConfW'(1);
            st_d = S_G_INIT;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      p_q    <= '0;
      q_q    <= '0;
      c_q    <= '0;
      k_q    <= '0;
      cc_q   <= '0;
      np_q   <= '0;
      leaf_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      p_q    <= p_d;
      q_q    <= q_d;
      c_q    <= c_d;
      k_q    <= k_d;
      cc_q   <= cc_d;
      np_q   <= np_d;
      leaf_q <= leaf_d;
    end
  end

endmodule

FILE: hw/rtl/astar_node_expand_scorer.sv
// Load, element and count beats are taken back to back.
// Build: input stalled; read and accumulate state per pair read, one per loop step.
// Expansion: input stalled; per child a read and an accumulate state per one-body,
// pair or minima read, one per skipped index or loop step, and a stalled result
// holds the controller. Reset clears control, node state and the constant, sets
// counts to one, npos to MaxPos; energy memories are garbage until written or built.
`timescale 1ns / 1ps

module astar_node_expand_scorer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [anes_pkg::EnergyW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   kind_i,
  input  logic [anes_pkg::PosW-1:0]    pos_a_i,
  input  logic [anes_pkg::ConfW-1:0]   conf_a_i,
  input  logic [anes_pkg::PosW-1:0]    pos_b_i,
  input  logic [anes_pkg::ConfW-1:0]   conf_b_i,
  input  logic signed [anes_pkg::EnergyW-1:0] energy_value_i,
  input  logic [anes_pkg::CntW-1:0]    conf_count_i,
  input  logic                         is_assigned_i,
  input  logic                         last_element_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [anes_pkg::PosW-1:0]    child_position_o,
  output logic [anes_pkg::ConfW-1:0]   child_conf_o,
  output logic signed [anes_pkg::SumW-1:0] exact_score_o,
  output logic signed [anes_pkg::SumW-1:0] bound_score_o,
  output logic                         parent_was_leaf_o,
  output logic                         last_child_o
);
  import anes_pkg::*;

  anes_cmd_t cmd;
  anes_sts_t sts;

  anes_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .last_element_i(last_element_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  anes_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .kind_i           (kind_i),
    .pos_a_i          (pos_a_i),
    .conf_a_i         (conf_a_i),
    .pos_b_i          (pos_b_i),
    .conf_b_i         (conf_b_i),
    .energy_value_i   (energy_value_i),
    .conf_count_i     (conf_count_i),
    .is_assigned_i    (is_assigned_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .child_position_o (child_position_o),
    .child_conf_o     (child_conf_o),
    .exact_score_o    (exact_score_o),
    .bound_score_o    (bound_score_o),
    .parent_was_leaf_o(parent_was_leaf_o),
    .last_child_o     (last_child_o)
  );

  a_last_elem_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i == KIND_NODE && last_element_i) |=> in_stall_o)
    else $error("input not stalled after last node element");

  a_build_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i == KIND_BUILD) |=> in_stall_o)
    else $error("input not stalled after build command");

  a_leaf_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && parent_was_leaf_o) |-> (last_child_o && bound_score_o == '0))
    else $error("leaf result without last mark or with nonzero bound");

  a_leaf_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && parent_was_leaf_o) |-> (child_position_o == '0 && child_conf_o == '0))
    else $error("leaf result with nonzero position or conformation");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for astar_node_expand_scorer: loads energies, builds
// pair minima, streams parent nodes and checks every child against a predictor.
// Depends on anes_pkg and the scorer RTL.
`timescale 1ns / 1ps

module tb;
  import anes_pkg::*;

  localparam longint SumMax = (64'sd1 <<< (SumW - 1)) - 1;
  localparam longint SumMin = -SumMax - 1;
  localparam longint CycleLimit = 1000000;
  // counts stay at or below this and assigned conformations below it, so scoring only
  // reaches filled entries
  localparam int FillConfs = 2;

  // kinds the scorer ignores
  localparam logic [2:0] KIND_SPARE5 = 3'd5;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic [PosW-1:0]        pos;
    logic [ConfW-1:0]       conf;
    logic signed [SumW-1:0] exact;
    logic signed [SumW-1:0] bound;
    logic                   leaf;
    logic                   last;
  } child_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [PosW-1:0]    pa;
    logic [ConfW-1:0]   ca;
    logic [PosW-1:0]    pb;
    logic [ConfW-1:0]   cb;
    logic [EnergyW-1:0] ev;
    logic [CntW-1:0]    cnt;
    logic               asg;
    logic               lst;
    logic               typed;
    child_t             want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = REG_NUM_POS;
  logic [EnergyW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = KIND_SINGLE;
  logic [PosW-1:0] pos_a = '0, pos_b = '0;
  logic [ConfW-1:0] conf_a = '0, conf_b = '0;
  logic signed [EnergyW-1:0] energy_value = '0;
  logic [CntW-1:0] conf_count = '0;
  logic is_assigned = 1'b0, last_element = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PosW-1:0] child_position;
  logic [ConfW-1:0] child_conf;
  logic signed [SumW-1:0] exact_score, bound_score;
  logic parent_was_leaf, last_child;

  astar_node_expand_scorer DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .pos_a_i(pos_a), .conf_a_i(conf_a), .pos_b_i(pos_b),
    .conf_b_i(conf_b), .energy_value_i(energy_value), .conf_count_i(conf_count),
    .is_assigned_i(is_assigned), .last_element_i(last_element),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .child_position_o(child_position), .child_conf_o(child_conf),
    .exact_score_o(exact_score), .bound_score_o(bound_score),
    .parent_was_leaf_o(parent_was_leaf), .last_child_o(last_child)
  );

  always #1 clk = ~clk;

  // scorer state as the predictor sees it
  longint one_body[MaxPos*MaxConfs];
  longint pair_e[MaxPos*MaxConfs*MaxPos*MaxConfs];
  longint pair_floor[MaxPos*MaxConfs*MaxPos];
  int unsigned conf_cnt[MaxPos];
  bit node_flag[MaxPos];
  int unsigned node_choice[MaxPos];
  int unsigned npos_r;
  longint const_r;
  bit work_flag[MaxPos];
  int unsigned work_choice[MaxPos];

  child_t pending_children[$];
  bit failed = 1'b0;
  longint cycles = 0;
  int stall_left = 0;

  function automatic void queue_child(child_t r);
    pending_children = {pending_children, r};
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    longint s;
    s = a + b;
    return s > SumMax ? SumMax : (s < SumMin ? SumMin : s);
  endfunction

  function automatic int pair_at(int hp, int hc, int lp, int lc);
    return ((hp * MaxConfs + hc) * MaxPos + lp) * MaxConfs + lc;
  endfunction

  function automatic longint pair_of(int p1, int c1, int p2, int c2);
    return p1 > p2 ? pair_e[pair_at(p1, c1, p2, c2)] : pair_e[pair_at(p2, c2, p1, c1)];
  endfunction

  function automatic void build_floors();
    longint m;
    for (int p = 0; p < npos_r; p++)
      for (int c = 0; c < conf_cnt[p]; c++)
        for (int q = 0; q < p; q++) begin
          m = pair_e[pair_at(p, c, q, 0)];
          for (int k = 1; k < conf_cnt[q]; k++)
            if (pair_e[pair_at(p, c, q, k)] < m) m = pair_e[pair_at(p, c, q, k)];
          pair_floor[(p * MaxConfs + c) * MaxPos + q] = m;
        end
  endfunction

  function automatic longint exact_score_of();
    longint g;
    g = const_r;
    for (int p = 0; p < npos_r; p++)
      if (work_flag[p]) g = sum_sat(g, one_body[p * MaxConfs + work_choice[p]]);
    for (int p = 0; p < npos_r; p++)
      if (work_flag[p])
        for (int q = 0; q < p; q++)
          if (work_flag[q]) g = sum_sat(g, pair_of(p, work_choice[p], q, work_choice[q]));
    return g;
  endfunction

  function automatic longint bound_score_of();
    longint h, best, e;
    h = 0;
    for (int p = 0; p < npos_r; p++) begin
      if (work_flag[p]) continue;
      best = 0;
      for (int c = 0; c < conf_cnt[p]; c++) begin
        e = one_body[p * MaxConfs + c];
        for (int q = 0; q < npos_r; q++)
          if (work_flag[q] && q != p) e = sum_sat(e, pair_of(p, c, q, work_choice[q]));
        for (int q = 0; q < p; q++)
          if (!work_flag[q]) e = sum_sat(e, pair_floor[(p * MaxConfs + c) * MaxPos + q]);
        if (c == 0 || e < best) best = e;
      end
      h = sum_sat(h, best);
    end
    return h;
  endfunction

  // expand the parent held in node state; append children to the queue
  function automatic void expand_parent();
    child_t r;
    int nxt;
    nxt = -1;
    work_flag = node_flag;
    work_choice = node_choice;
    for (int p = 0; p < npos_r; p++)
      if (!work_flag[p] && nxt < 0) nxt = p;
    if (nxt < 0) begin
      r = '{pos: '0, conf: '0, exact: SumW'(exact_score_of()), bound: '0, leaf: 1'b1,
            last: 1'b1};
      queue_child(r);
      return;
    end
    work_flag[nxt] = 1'b1;
    for (int c = 0; c < conf_cnt[nxt]; c++) begin
      work_choice[nxt] = c;
      r.pos = PosW'(nxt);
      r.conf = ConfW'(c);
      r.exact = SumW'(exact_score_of());
      r.bound = SumW'(bound_score_of());
      r.leaf = 1'b0;
      r.last = (c + 1 == conf_cnt[nxt]);
      queue_child(r);
    end
  endfunction

  function automatic void apply_beat(stim_t s);
    int unsigned n;
    case (s.kind)
      KIND_SINGLE: one_body[s.pa * MaxConfs + s.ca] = longint'(signed'(s.ev));
      KIND_PAIR:
        if (s.pa > s.pb) pair_e[pair_at(s.pa, s.ca, s.pb, s.cb)] = longint'(signed'(s.ev));
      KIND_COUNT: begin
        n = s.cnt;
        if (n < 1) n = 1;
        if (n > MaxConfs) n = MaxConfs;
        conf_cnt[s.pa] = n;
      end
      KIND_BUILD: build_floors();
      KIND_NODE: begin
        node_flag[s.pa] = s.asg;
        node_choice[s.pa] = s.asg ? s.ca : 0;
        if (s.lst) begin
          if (s.typed) queue_child(s.want);
          else expand_parent();
          node_flag = '{default: 1'b0};
          node_choice = '{default: 0};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(stim_t s);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    kind <= s.kind; pos_a <= s.pa; conf_a <= s.ca; pos_b <= s.pb; conf_b <= s.cb;
    energy_value <= s.ev; conf_count <= s.cnt; is_assigned <= s.asg;
    last_element <= s.lst; in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    apply_beat(s);
  endtask

  function automatic stim_t beat(logic [2:0] k, int pa, int ca, int pb, int cb,
                                 logic [31:0] ev, int cnt, bit asg, bit lst);
    stim_t s;
    s = '0;
    s.kind = k; s.pa = PosW'(pa); s.ca = ConfW'(ca); s.pb = PosW'(pb); s.cb = ConfW'(cb);
    s.ev = ev; s.cnt = CntW'(cnt); s.asg = asg; s.lst = lst;
    return s;
  endfunction

  function automatic logic [31:0] rand_energy();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h7fff_ffff;
    if (r == 1) return 32'h8000_0000;
    return $urandom();
  endfunction

  // an ignored beat proves any build has drained; then let the datapath settle
  task automatic wait_idle();
    send(beat(KIND_SPARE7, 0, 0, 0, 0, '0, 0, 0, 0));
    in_valid <= 1'b0;
    while (pending_children.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_NUM_POS) begin
      npos_r = val[3:0];
      if (npos_r < 1) npos_r = 1;
      if (npos_r > MaxPos) npos_r = MaxPos;
    end else begin
      const_r = longint'(signed'(val));
    end
  endtask

  task automatic send_parent();
    int order[MaxPos];
    int n, j, t;
    n = $urandom_range(1, MaxPos);
    for (int i = 0; i < MaxPos; i++) order[i] = i;
    for (int i = MaxPos - 1; i > 0; i--) begin
      j = $urandom_range(i); t = order[i]; order[i] = order[j]; order[j] = t;
    end
    // mostly assign the chosen positions so deep children show up
    for (int i = 0; i < n; i++)
      send(beat(KIND_NODE, order[i], $urandom_range(FillConfs - 1), $urandom_range(7),
                $urandom_range(15), rand_energy(), $urandom_range(31),
                $urandom_range(3) != 0, i == n - 1));
  endtask

  task automatic run_phase(logic [3:0] np, logic [31:0] cterm, int beats);
    int r;
    wait_idle();
    write_reg(REG_NUM_POS, np);
    write_reg(REG_CONST, cterm);
    for (int p = 0; p < MaxPos; p++)
      send(beat(KIND_COUNT, p, 0, 0, 0, '0, $urandom_range(0, FillConfs), 0, 0));
    send(beat(KIND_BUILD, 0, 0, 0, 0, $urandom(), 0, 0, 1));
    for (int i = 0; i < beats; i++) begin
      r = $urandom_range(99);
      if (r < 60) send_parent();
      else if (r < 75)
        send(beat(KIND_SINGLE, $urandom_range(7), $urandom_range(15), 0, 0,
                  rand_energy(), 0, 0, 0));
      else if (r < 87)
        send(beat(KIND_PAIR, $urandom_range(7), $urandom_range(15), $urandom_range(7),
                  $urandom_range(15), rand_energy(), 0, 0, 0));
      else if (r < 93) begin
        // a count change needs fresh minima before the next parent
        send(beat(KIND_COUNT, $urandom_range(7), 0, 0, 0, '0,
                  $urandom_range(0, FillConfs), 0, 0));
        send(beat(KIND_BUILD, 0, 0, 0, 0, '0, 0, 0, 0));
      end else if (r < 96) send(beat(KIND_BUILD, 0, 0, 0, 0, '0, 0, 0, 0));
      else send(beat(3'($urandom_range(KIND_SPARE5, KIND_SPARE7)), $urandom_range(7),
                     $urandom_range(15), $urandom_range(7), $urandom_range(15), $urandom(),
                     $urandom_range(31), $urandom_range(1), $urandom_range(1)));
    end
  endtask

  stim_t directed[$];

  initial begin
    child_t w;
    stim_t s;
    for (int i = 0; i < MaxPos * MaxConfs; i++) one_body[i] = 0;
    for (int i = 0; i < MaxPos * MaxConfs * MaxPos * MaxConfs; i++) pair_e[i] = 0;
    for (int i = 0; i < MaxPos * MaxConfs * MaxPos; i++) pair_floor[i] = 0;
    conf_cnt = '{default: 1};
    node_flag = '{default: 1'b0};
    node_choice = '{default: 0};
    npos_r = MaxPos;
    const_r = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill what scoring can reach: low conformations everywhere, all of position 0
    for (int p = 0; p < MaxPos; p++)
      for (int c = 0; c < (p == 0 ? MaxConfs : FillConfs); c++)
        send(beat(KIND_SINGLE, p, c, 0, 0, rand_energy(), 0, 0, 0));
    for (int p = 1; p < MaxPos; p++)
      for (int c = 0; c < FillConfs; c++)
        for (int q = 0; q < p; q++)
          for (int k = 0; k < FillConfs; k++)
            send(beat(KIND_PAIR, p, c, q, k, rand_energy(), 0, 0, 0));

    wait_idle();
    write_reg(REG_NUM_POS, 4'd1);
    write_reg(REG_CONST, 32'h7fff_ffff);
    directed = {directed, beat(KIND_SINGLE, 0, 3, 0, 0, 32'h7fff_ffff, 0, 0, 0)};
    directed = {directed, beat(KIND_SINGLE, 7, 15, 0, 0, 32'h8000_0000, 0, 0, 0)};
    directed = {directed, beat(KIND_PAIR, 2, 1, 5, 1, 32'h1234_5678, 0, 0, 0)};
    directed = {directed, beat(KIND_PAIR, 3, 0, 3, 0, 32'h7fff_ffff, 0, 0, 0)};
    directed = {directed, beat(KIND_PAIR, 1, 15, 0, 15, 32'h8000_0000, 0, 0, 0)};
    directed = {directed, beat(KIND_PAIR, 7, 15, 6, 0, 32'h7fff_ffff, 0, 0, 0)};
    directed = {directed, beat(KIND_COUNT, 1, 0, 0, 0, '0, 0, 0, 0)};
    directed = {directed, beat(KIND_COUNT, 0, 0, 0, 0, '0, 31, 0, 0)};
    directed = {directed, beat(KIND_COUNT, 2, 0, 0, 0, '0, 16, 0, 0)};
    directed = {directed, beat(KIND_BUILD, 0, 0, 0, 0, '0, 0, 0, 0)};
    directed = {directed, beat(KIND_SPARE5, 0, 0, 0, 0, '0, 0, 1, 1)};
    directed = {directed, beat(KIND_SPARE6, 7, 15, 7, 15, 32'hffff_ffff, 31, 1, 1)};
    directed = {directed, beat(KIND_SPARE7, 0, 0, 0, 0, '0, 0, 0, 1)};
    // leaf: constant and one-body both at the top of the range
    s = beat(KIND_NODE, 0, 3, 0, 0, '0, 0, 1, 1);
    w = '{pos: '0, conf: '0, exact: 40'sd4294967294, bound: '0, leaf: 1'b1, last: 1'b1};
    s.typed = 1'b1; s.want = w;
    directed = {directed, s};
    directed = {directed, beat(KIND_NODE, 0, 0, 0, 0, '0, 0, 0, 1)};
    directed = {directed, beat(KIND_NODE, 0, 15, 0, 0, '0, 0, 1, 0)};
    directed = {directed, beat(KIND_NODE, 7, 9, 0, 0, '0, 0, 1, 1)};
    directed = {directed, beat(KIND_NODE, 5, 2, 0, 0, '0, 0, 1, 0)};
    directed = {directed, beat(KIND_NODE, 0, 0, 0, 0, '0, 0, 0, 1)};
    foreach (directed[i]) send(directed[i]);

    run_phase(4'd8, 32'h8000_0000, 5);
    run_phase(4'd0, 32'h0000_0000, 5);
    run_phase(4'd15, 32'h0001_8000, 5);
    run_phase(4'($urandom_range(2, 5)), $urandom(), 5);

    in_valid <= 1'b0;
    while (pending_children.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: check each beat, then pick the next stall
  always @(posedge clk) begin
    child_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_children.size() == 0) begin
        $display("%0t: expected no child, actual pos=%0d conf=%0d", $time, child_position,
                 child_conf);
        failed = 1'b1;
      end else begin
        e = pending_children.pop_front();
        if (child_position !== e.pos || child_conf !== e.conf || exact_score !== e.exact ||
            bound_score !== e.bound || parent_was_leaf !== e.leaf || last_child !== e.last) begin
          $display("%0t: expected pos=%0d conf=%0d g=%0d h=%0d leaf=%0b last=%0b", $time,
                   e.pos, e.conf, e.exact, e.bound, e.leaf, e.last);
          $display("%0t: actual   pos=%0d conf=%0d g=%0d h=%0d leaf=%0b last=%0b", $time,
                   child_position, child_conf, exact_score, bound_score, parent_was_leaf,
                   last_child);
          failed = 1'b1;
        end
      end
    end
    // hold stall for a whole gap, then pick the next one
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left = gap_len();
      out_stall <= (stall_left != 0);
    end
  end

endmodule
